### src/itoa_pkg.sv
// Shared types, constants and helpers of the integer to ASCII formatter.
`timescale 1ns / 1ps

package itoa_pkg;

  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned DIGITS_W   = 4 * NUM_DIGITS;
  localparam int unsigned NDIG_W     = 4;

  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;

  typedef enum logic [1:0] {
    FMT_SDEC = 2'd0,
    FMT_UDEC = 2'd1,
    FMT_HEXL = 2'd2,
    FMT_HEXU = 2'd3
  } fmt_e;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_CONV,
    FR_PUSH
  } front_state_e;

  typedef enum logic {
    BK_IDLE,
    BK_EMIT
  } back_state_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } out_item_t;

  // One value ready for printing: digits left-aligned, most significant nibble first.
  typedef struct packed {
    logic [DIGITS_W-1:0] digits;
    logic [NDIG_W-1:0]   ndig;
    logic                neg;
    logic                upper;
  } job_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    if (d < 4'd10) begin
      return CHAR_ZERO + {4'h0, d};
    end
    base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
    return base + {4'h0, d} - 8'd10;
  endfunction

endpackage

### src/itoa_front.sv
// Front end: accepts a word, resolves sign and radix, and builds its digit string.
`timescale 1ns / 1ps

module itoa_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  itoa_pkg::in_item_t item_i,
  output logic               push_o,
  input  logic               full_i,
  output itoa_pkg::job_t     job_o
);

  itoa_pkg::front_state_e state_q, state_d;

  logic [31:0]                   mag_q;
  logic [itoa_pkg::DIGITS_W-1:0] bcd_q;
  logic [2:0]                    step_q;
  logic                          neg_q;
  logic                          upper_q;

  logic                          accept;
  logic                          is_sdec;
  logic                          is_dec;
  logic [31:0]                   in_mag;
  logic [itoa_pkg::DIGITS_W-1:0] dd_bcd;
  logic [31:0]                   dd_mag;
  logic [itoa_pkg::NDIG_W-1:0]   top_idx;
  logic [itoa_pkg::NDIG_W-1:0]   ndig;
  logic [itoa_pkg::NDIG_W-1:0]   shamt;

  assign accept  = start && (state_q == itoa_pkg::FR_IDLE);
  assign is_sdec = (itoa_pkg::fmt_e'(item_i.action) == itoa_pkg::FMT_SDEC);
  assign is_dec  = is_sdec || (itoa_pkg::fmt_e'(item_i.action) == itoa_pkg::FMT_UDEC);
  // Negating the most negative word gives back 0x80000000, read as unsigned.
  assign in_mag  = (is_sdec && item_i.value[31]) ? (32'd0 - item_i.value) : item_i.value;

  // Four double-dabble steps per cycle; step_q paces them over the 32-bit word.
  always_comb begin
    dd_bcd = bcd_q;
    dd_mag = mag_q;
    for (int s = 0; s < 4; s++) begin
      for (int d = 0; d < itoa_pkg::NUM_DIGITS; d++) begin
        if (dd_bcd[4*d +: 4] >= 4'd5) begin
          dd_bcd[4*d +: 4] = dd_bcd[4*d +: 4] + 4'd3;
        end
      end
      dd_bcd = {dd_bcd[itoa_pkg::DIGITS_W-2:0], dd_mag[31]};
      dd_mag = {dd_mag[30:0], 1'b0};
    end
  end

  // Highest nonzero digit sets the length; zero still prints one digit.
  always_comb begin
    top_idx = '0;
    for (int d = 0; d < itoa_pkg::NUM_DIGITS; d++) begin
      if (bcd_q[4*d +: 4] != 4'h0) begin
        top_idx = itoa_pkg::NDIG_W'(d);
      end
    end
    ndig  = top_idx + 1'b1;
    shamt = itoa_pkg::NDIG_W'(itoa_pkg::NUM_DIGITS) - ndig;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      itoa_pkg::FR_IDLE: begin
        if (accept) begin
          state_d = is_dec ? itoa_pkg::FR_CONV : itoa_pkg::FR_PUSH;
        end
      end
      itoa_pkg::FR_CONV: begin
        if (step_q == 3'd7) begin
          state_d = itoa_pkg::FR_PUSH;
        end
      end
      itoa_pkg::FR_PUSH: begin
        if (!full_i) begin
          state_d = itoa_pkg::FR_IDLE;
        end
      end
      default: state_d = itoa_pkg::FR_IDLE;
    endcase
  end

  always_comb begin
    busy         = (state_q != itoa_pkg::FR_IDLE);
    push_o       = (state_q == itoa_pkg::FR_PUSH) && !full_i;
    job_o.digits = bcd_q << {shamt, 2'b00};
    job_o.ndig   = ndig;
    job_o.neg    = neg_q;
    job_o.upper  = upper_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itoa_pkg::FR_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        step_q <= '0;
      end else if (state_q == itoa_pkg::FR_CONV) begin
        step_q <= step_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      neg_q   <= is_sdec && item_i.value[31];
      upper_q <= (itoa_pkg::fmt_e'(item_i.action) == itoa_pkg::FMT_HEXU);
      mag_q   <= in_mag;
      bcd_q   <= is_dec ? '0 : {8'h00, item_i.value};
    end else if (state_q == itoa_pkg::FR_CONV) begin
      mag_q <= dd_mag;
      bcd_q <= dd_bcd;
    end
  end

endmodule

### src/itoa_queue.sv
// Small FIFO of prepared digit strings between the front and back ends.
`timescale 1ns / 1ps

module itoa_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  itoa_pkg::job_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output itoa_pkg::job_t pop_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  itoa_pkg::job_t mem_q [DEPTH];

  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### src/itoa_back.sv
// Back end: emits the sign and digits of one prepared value, one character a cycle.
`timescale 1ns / 1ps

module itoa_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  itoa_pkg::job_t      job_i,
  output logic                pop_o,
  output logic                result_valid_o,
  output itoa_pkg::out_item_t result_o
);

  itoa_pkg::back_state_e state_q, state_d;

  logic [itoa_pkg::DIGITS_W-1:0] digits_q;
  logic [itoa_pkg::NDIG_W-1:0]   rem_q;
  logic                          neg_q;
  logic                          upper_q;
  logic                          out_valid_q;
  itoa_pkg::out_item_t           out_q;

  logic                emit;
  logic                emit_last;
  itoa_pkg::out_item_t emit_item;

  always_comb begin
    emit      = (state_q == itoa_pkg::BK_EMIT);
    emit_last = emit && !neg_q && (rem_q == itoa_pkg::NDIG_W'(1));
    // The next value may load in the cycle that sends the last character of this one.
    pop_o     = valid_i && ((state_q == itoa_pkg::BK_IDLE) || emit_last);
    emit_item.last      = emit_last;
    emit_item.char_code = neg_q ? itoa_pkg::CHAR_MINUS :
        itoa_pkg::digit_char(digits_q[itoa_pkg::DIGITS_W-1 -: 4], upper_q);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      itoa_pkg::BK_IDLE: begin
        if (pop_o) begin
          state_d = itoa_pkg::BK_EMIT;
        end
      end
      itoa_pkg::BK_EMIT: begin
        if (emit_last && !pop_o) begin
          state_d = itoa_pkg::BK_IDLE;
        end
      end
      default: state_d = itoa_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= itoa_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= emit_item;
    if (pop_o) begin
      digits_q <= job_i.digits;
      rem_q    <= job_i.ndig;
      neg_q    <= job_i.neg;
      upper_q  <= job_i.upper;
    end else if (emit) begin
      if (neg_q) begin
        neg_q <= 1'b0;
      end else begin
        digits_q <= {digits_q[itoa_pkg::DIGITS_W-5:0], 4'h0};
        rem_q    <= rem_q - 1'b1;
      end
    end
  end

  assign result_valid_o = out_valid_q;
  assign result_o       = out_q;

endmodule

### src/integer_to_ascii_formatter_core.sv
// Top level of the integer to ASCII formatter: front end, job queue and back end.
`timescale 1ns / 1ps

// Converts a 32-bit word to decimal or hex text and sends it one character at a time.
// Input: drive item_i (action selects signed decimal, unsigned decimal, lowercase hex
// or uppercase hex) and raise start; the transfer happens at a clock edge where start
// is high and busy is low. Output: result_valid_o is high for one cycle per character
// in result_o; result_o.last marks the final character of a value. Characters of one
// value leave on consecutive cycles, most significant digit first, with a leading
// minus for negative signed values and no leading zeros.
// A hex item goes from FR_PUSH through the queue into BK_EMIT and the output register;
// a decimal item first passes FR_CONV, the binary to BCD converter (4 bits per cycle).
// The back end sends one character per cycle; the front end takes a new item once it
// has pushed the last one and works ahead while the queue has room, so the slower of
// the two sets the rate.
// The receiver cannot stall: every character is taken in the cycle it is shown.
// Reset clears the front end, the queue and the back end; no text is in flight after.

module integer_to_ascii_formatter_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  itoa_pkg::in_item_t  item_i,
  output logic                result_valid_o,
  output itoa_pkg::out_item_t result_o
);

  logic           push;
  logic           full;
  logic           pop;
  logic           q_valid;
  itoa_pkg::job_t front_job;
  itoa_pkg::job_t back_job;

  itoa_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .item_i (item_i),
    .push_o (push),
    .full_i (full),
    .job_o  (front_job)
  );

  itoa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_job),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (back_job)
  );

  itoa_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (q_valid),
    .job_i          (back_job),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

### src/itoa_checker.sv
// Port-level checks of the formatter, attached to the top level by bind.
`timescale 1ns / 1ps

module itoa_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                result_valid_o,
  input itoa_pkg::out_item_t result_o
);

  // Characters of one value are never split by an idle cycle.
  a_run_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last |=> result_valid_o)
    else $error("character run broken before its last character");

  // A minus sign always has at least one digit after it.
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (result_o.char_code == itoa_pkg::CHAR_MINUS) |-> !result_o.last)
    else $error("minus sign marked as last character");

  // A minus sign only opens a run.
  a_minus_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (result_o.char_code == itoa_pkg::CHAR_MINUS) |->
      (!$past(result_valid_o) || $past(result_o.last)))
    else $error("minus sign in the middle of a run");

  // A transfer always makes the block busy for at least the next cycle.
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("not busy right after an input transfer");

endmodule

bind integer_to_ascii_formatter_core itoa_checker u_itoa_checker (.*);

### tb/sv/tb_top.sv
// Self-checking testbench for the integer to ASCII formatter core.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned DRAIN_CYCLES = 30;
  localparam int unsigned ITEMS_PER_PHASE = 100;

  // Predicts the characters of every accepted value and checks them in order.
  class text_scoreboard;
    itoa_pkg::out_item_t expected_chars[$];
    int unsigned values_noted;
    int unsigned chars_checked;
    int unsigned errors;

    function new();
      values_noted  = 0;
      chars_checked = 0;
      errors        = 0;
    endfunction

    static function logic [7:0] digit_glyph(logic [3:0] d, logic upper);
      if (d < 4'd10) begin
        return 8'("0") + 8'(d);
      end
      return (upper ? 8'("A") : 8'("a")) + 8'(d) - 8'd10;
    endfunction

    function void note_item(itoa_pkg::in_item_t it);
      itoa_pkg::fmt_e      fmt;
      logic [31:0]         mag;
      logic [31:0]         radix;
      logic [3:0]          rev [10];
      int                  n;
      logic                neg;
      logic                upper;
      itoa_pkg::out_item_t ch;
      fmt   = itoa_pkg::fmt_e'(it.action);
      mag   = it.value;
      neg   = 1'b0;
      upper = (fmt == itoa_pkg::FMT_HEXU);
      radix = (fmt == itoa_pkg::FMT_HEXL || fmt == itoa_pkg::FMT_HEXU) ? 32'd16 : 32'd10;
      // The negated most negative word is still 0x80000000, read as unsigned.
      if (fmt == itoa_pkg::FMT_SDEC && it.value[31]) begin
        neg = 1'b1;
        mag = 32'd0 - it.value;
      end
      n = 0;
      do begin
        rev[n] = 4'(mag % radix);
        mag    = mag / radix;
        n++;
      end while (mag != 0 && n < 10);
      if (neg) begin
        ch.char_code = 8'("-");
        ch.last      = 1'b0;
        expected_chars.push_back(ch);
      end
      for (int i = n - 1; i >= 0; i--) begin
        ch.char_code = digit_glyph(rev[i], upper);
        ch.last      = (i == 0);
        expected_chars.push_back(ch);
      end
      values_noted++;
    endfunction

    function void check_char(itoa_pkg::out_item_t got);
      itoa_pkg::out_item_t want;
      if (expected_chars.size() == 0) begin
        $error("unexpected character: char_code 0x%02h last %0b", got.char_code, got.last);
        errors++;
        return;
      end
      want = expected_chars.pop_front();
      chars_checked++;
      if (got.char_code !== want.char_code) begin
        $error("char_code mismatch: expected 0x%02h actual 0x%02h",
               want.char_code, got.char_code);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last mismatch: expected %0b actual %0b", want.last, got.last);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_chars.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  itoa_pkg::in_item_t  item_i;
  logic                result_valid_o;
  itoa_pkg::out_item_t result_o;

  text_scoreboard text_sb;
  int unsigned    quiet_cycles;

  integer_to_ascii_formatter_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result monitor and stall watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) begin
        text_sb.check_char(result_o);
      end
      if (result_valid_o || (start && !busy)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles, %0d characters outstanding.",
                 STALL_LIMIT, text_sb.pending());
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_value(itoa_pkg::in_item_t it, int unsigned idle_pct);
    itoa_pkg::in_item_t junk;
    while ($urandom_range(99) < idle_pct) begin
      junk.action = 2'($urandom);
      junk.value  = $urandom;
      start  <= 1'b0;
      item_i <= junk;
      @(negedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    text_sb.note_item(it);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] random_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(5))
      0: return w >> $urandom_range(31);
      1: return 32'($urandom_range(20));
      2: return 32'd0 - 32'($urandom_range(20));
      3: begin
        case ($urandom_range(5))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          3: return 32'd999_999_999;
          4: return 32'd1_000_000_000;
          default: return 32'h1000_0000;
        endcase
      end
      default: return w;
    endcase
  endfunction

  task automatic run_random(int unsigned count, int unsigned idle_pct);
    itoa_pkg::in_item_t it;
    for (int unsigned k = 0; k < count; k++) begin
      it.action = 2'($urandom_range(3));
      it.value  = random_word();
      send_value(it, idle_pct);
    end
  endtask

  initial begin
    itoa_pkg::in_item_t directed [$];
    text_sb      = new();
    quiet_cycles = 0;
    rst_ni       = 1'b0;
    start        = 1'b0;
    item_i       = '0;

    // Zero in every format, the all-ones word in every format, the most
    // negative word, and digit and letter boundaries.
    directed = '{
      '{action: itoa_pkg::FMT_SDEC, value: 32'h0000_0000},
      '{action: itoa_pkg::FMT_UDEC, value: 32'h0000_0000},
      '{action: itoa_pkg::FMT_HEXL, value: 32'h0000_0000},
      '{action: itoa_pkg::FMT_HEXU, value: 32'h0000_0000},
      '{action: itoa_pkg::FMT_SDEC, value: 32'h8000_0000},
      '{action: itoa_pkg::FMT_SDEC, value: 32'h7FFF_FFFF},
      '{action: itoa_pkg::FMT_SDEC, value: 32'hFFFF_FFFF},
      '{action: itoa_pkg::FMT_UDEC, value: 32'hFFFF_FFFF},
      '{action: itoa_pkg::FMT_HEXL, value: 32'hFFFF_FFFF},
      '{action: itoa_pkg::FMT_HEXU, value: 32'hFFFF_FFFF},
      '{action: itoa_pkg::FMT_UDEC, value: 32'h8000_0000},
      '{action: itoa_pkg::FMT_HEXL, value: 32'h8000_0000},
      '{action: itoa_pkg::FMT_SDEC, value: 32'd9},
      '{action: itoa_pkg::FMT_SDEC, value: 32'd10},
      '{action: itoa_pkg::FMT_UDEC, value: 32'd1_000_000_000},
      '{action: itoa_pkg::FMT_UDEC, value: 32'd999_999_999},
      '{action: itoa_pkg::FMT_HEXL, value: 32'h0000_000F},
      '{action: itoa_pkg::FMT_HEXU, value: 32'h0000_0010},
      '{action: itoa_pkg::FMT_HEXL, value: 32'hABCD_EF01},
      '{action: itoa_pkg::FMT_HEXU, value: 32'hABCD_EF01},
      '{action: itoa_pkg::FMT_HEXU, value: 32'h1234_5678},
      '{action: itoa_pkg::FMT_SDEC, value: 32'hFFFF_FFF6},
      '{action: itoa_pkg::FMT_UDEC, value: 32'd1}
    };

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) begin
      send_value(directed[i], 23);
    end
    run_random(ITEMS_PER_PHASE, 23);
    run_random(ITEMS_PER_PHASE, 87);
    run_random(ITEMS_PER_PHASE, 0);
    start <= 1'b0;

    while (text_sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d values in all four formats under light, heavy and no input gaps.",
             text_sb.values_noted);
    $display("Checked %0d characters, %0d mismatches.", text_sb.chars_checked,
             text_sb.errors);
    if (text_sb.errors == 0 && text_sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### integer_to_ascii_formatter_core.f
src/itoa_pkg.sv
src/itoa_front.sv
src/itoa_queue.sv
src/itoa_back.sv
src/integer_to_ascii_formatter_core.sv
src/itoa_checker.sv
tb/sv/tb_top.sv
